// ===== hw/rtl/rhtt_pkg.sv =====
// Package for the rectangle hit-test table.
// Holds opcodes, status codes, FSM states, entry layout and the
// command/status structs shared by controller and datapath.
package rhtt_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REPLACE  = 3'd1,
    OP_REM_IDX  = 3'd2,
    OP_REM_KEYS = 3'd3,
    OP_REM_TYPE = 3'd4,
    OP_HIT      = 3'd5,
    OP_LOOKUP   = 3'd6,
    OP_CLEAR    = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [6:0] LIMIT_RESET = 7'd64;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [15:0]        pos;
    logic [7:0]         typ;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [16:0] right;
    logic signed [16:0] bottom;
  } entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

// ===== hw/rtl/rect_hit_test_table.sv =====
// Rectangle hit-test table: ordered table of keyed rectangles.
// Instantiates rhtt_ctrl and rhtt_dp; depends on rhtt_pkg.
//
// Usage:
//   Input: drive the fields and pulse start; the item is taken at an edge
//   where start is high and busy is low. busy stays high while it runs.
//   Result: out_valid is high for exactly one cycle with all out_ fields;
//   the receiver cannot stall, so it must take the item in that cycle.
//   Config: cfg_valid/cfg_ready write entry_limit (cfg_ready is always
//   high); write it only while the block is idle.
// Sequence: each item is loaded, then the entries it needs are read from
//   the entry memory, one entry per cycle; the last read is compared, the
//   item finishes and the result register is written. Add, clear and
//   scans of an empty table read no entries.
//   Queries stop at the first hit, scanning from the newest entry down.
//   Busy drops as the result appears, so the next start may be taken in
//   that cycle.
// Reset: empties the table and sets entry_limit to 64; the entry memory
//   itself is not cleared and needs no clearing pass.
module rect_hit_test_table
  import rhtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_opcode,
  input  logic [15:0]        in_key_position,
  input  logic [7:0]         in_key_type,
  input  logic signed [15:0] in_rect_left,
  input  logic signed [15:0] in_rect_top,
  input  logic [14:0]        in_rect_length,
  input  logic [14:0]        in_rect_width,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic [5:0]         in_entry_index,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [5:0]         out_found_index,
  output logic [15:0]        out_found_position,
  output logic [7:0]         out_found_type,
  output logic signed [15:0] out_found_left,
  output logic signed [15:0] out_found_top,
  output logic signed [16:0] out_found_right,
  output logic signed [16:0] out_found_bottom,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_entry_limit
);

  cmd_t cmd;
  sts_t sts;

  // accept limit writes at any time
  assign cfg_ready = 1'b1;

  rhtt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  rhtt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_data           (cfg_entry_limit),
    .in_opcode          (in_opcode),
    .in_key_position    (in_key_position),
    .in_key_type        (in_key_type),
    .in_rect_left       (in_rect_left),
    .in_rect_top        (in_rect_top),
    .in_rect_length     (in_rect_length),
    .in_rect_width      (in_rect_width),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_entry_index     (in_entry_index),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_index    (out_found_index),
    .out_found_position (out_found_position),
    .out_found_type     (out_found_type),
    .out_found_left     (out_found_left),
    .out_found_top      (out_found_top),
    .out_found_right    (out_found_right),
    .out_found_bottom   (out_found_bottom)
  );

endmodule

// ===== hw/rtl/rhtt_ctrl.sv =====
// Controller for the rectangle hit-test table.
// Sequences load, scan and finish; depends on rhtt_pkg.
module rhtt_ctrl
  import rhtt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    busy       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (sts.done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rhtt_dp.sv =====
// Datapath for the rectangle hit-test table: entry memory, scan pointers,
// compare logic and result register. Depends on rhtt_pkg.
module rhtt_dp
  import rhtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
)(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  logic [2:0]         in_opcode,
  input  logic [15:0]        in_key_position,
  input  logic [7:0]         in_key_type,
  input  logic signed [15:0] in_rect_left,
  input  logic signed [15:0] in_rect_top,
  input  logic [14:0]        in_rect_length,
  input  logic [14:0]        in_rect_width,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic [5:0]         in_entry_index,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [5:0]         out_found_index,
  output logic [15:0]        out_found_position,
  output logic [7:0]         out_found_type,
  output logic signed [15:0] out_found_left,
  output logic signed [15:0] out_found_top,
  output logic signed [16:0] out_found_right,
  output logic signed [16:0] out_found_bottom
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t mem [TABLE_DEPTH];

  logic [6:0]         limit_r;
  logic [CW-1:0]      count_r;
  op_t                op_r;
  entry_t             new_r;
  logic signed [15:0] px_r, py_r;
  logic [5:0]         idx_r;
  logic               idx_ok_r;
  logic [CW-1:0]      remain_r;
  logic [AW-1:0]      rd_addr_r;
  logic               pend_r;
  logic [AW-1:0]      pend_addr_r;
  entry_t             rd_q_r;
  logic [CW-1:0]      wr_ptr_r;
  logic               any_r;

  logic               is_compact, is_query, add_ok;
  logic               key_eq, type_eq, in_rect, hit, drop;
  logic signed [16:0] px_e, py_e;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic               issue;

  assign is_compact = (op_r == OP_REM_IDX) || (op_r == OP_REM_KEYS) ||
                      (op_r == OP_REM_TYPE);
  assign is_query   = (op_r == OP_HIT) || (op_r == OP_LOOKUP);
  assign add_ok     = (32'(count_r) < 32'(limit_r)) &&
                      (32'(count_r) < TABLE_DEPTH);

  // compare the entry read last cycle
  assign type_eq = (rd_q_r.typ == new_r.typ);
  assign key_eq  = type_eq && (rd_q_r.pos == new_r.pos);
  assign px_e    = {px_r[15], px_r};
  assign py_e    = {py_r[15], py_r};
  assign in_rect = (px_r >= rd_q_r.left) && (px_e < rd_q_r.right) &&
                   (py_r >= rd_q_r.top) && (py_e < rd_q_r.bottom);
  assign hit     = (op_r == OP_HIT) ? in_rect : key_eq;

  always_comb begin
    case (op_r)
      OP_REM_IDX:  drop = (32'(pend_addr_r) == 32'(idx_r));
      OP_REM_KEYS: drop = key_eq;
      OP_REM_TYPE: drop = type_eq;
      default:     drop = 1'b0;
    endcase
  end

  assign sts.done = cmd.step &&
                    ((remain_r == '0 && !pend_r) || (pend_r && is_query && hit));
  assign issue    = cmd.step && (remain_r != '0);

  // select the memory write
  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_r;
    wdata = rd_q_r;
    if (cmd.finish && op_r == OP_ADD && add_ok) begin
      we    = 1'b1;
      waddr = count_r[AW-1:0];
      wdata = new_r;
    end else if (cmd.step && pend_r && op_r == OP_REPLACE && key_eq) begin
      we           = 1'b1;
      wdata.left   = new_r.left;
      wdata.top    = new_r.top;
      wdata.right  = new_r.right;
      wdata.bottom = new_r.bottom;
    end else if (cmd.step && pend_r && is_compact && !drop) begin
      we    = 1'b1;
      waddr = wr_ptr_r[AW-1:0];
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rd_q_r <= mem[rd_addr_r];
    end
  end

  // capture the item and walk the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      remain_r <= '0;
    end else if (cmd.load) begin
      op_r         <= op_t'(in_opcode);
      new_r.pos    <= in_key_position;
      new_r.typ    <= in_key_type;
      new_r.left   <= in_rect_left;
      new_r.top    <= in_rect_top;
      new_r.right  <= {in_rect_left[15], in_rect_left} + {2'b00, in_rect_length};
      new_r.bottom <= {in_rect_top[15], in_rect_top} + {2'b00, in_rect_width};
      px_r         <= in_point_x;
      py_r         <= in_point_y;
      idx_r        <= in_entry_index;
      idx_ok_r     <= (32'(in_entry_index) < 32'(count_r));
      pend_r       <= 1'b0;
      wr_ptr_r     <= '0;
      any_r        <= 1'b0;
      case (op_t'(in_opcode))
        OP_REPLACE, OP_REM_KEYS, OP_REM_TYPE: begin
          remain_r  <= count_r;
          rd_addr_r <= '0;
        end
        OP_REM_IDX: begin
          remain_r  <= (32'(in_entry_index) < 32'(count_r)) ? count_r : '0;
          rd_addr_r <= '0;
        end
        OP_HIT, OP_LOOKUP: begin
          remain_r  <= count_r;
          rd_addr_r <= AW'(count_r - 1'b1);
        end
        default: begin
          remain_r  <= '0;
          rd_addr_r <= '0;
        end
      endcase
    end else if (cmd.step) begin
      pend_r <= issue;
      if (issue) begin
        pend_addr_r <= rd_addr_r;
        remain_r    <= remain_r - 1'b1;
        rd_addr_r   <= is_query ? rd_addr_r - 1'b1 : rd_addr_r + 1'b1;
      end
      if (pend_r) begin
        if (is_compact && !drop) begin
          wr_ptr_r <= wr_ptr_r + 1'b1;
        end
        if ((is_compact && drop) || (op_r == OP_REPLACE && key_eq)) begin
          any_r <= 1'b1;
        end
      end
    end
  end

  // entry count and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.finish) begin
        if (op_r == OP_ADD && add_ok) begin
          count_r <= count_r + 1'b1;
        end else if (op_r == OP_CLEAR) begin
          count_r <= '0;
        end else if (is_compact && (op_r != OP_REM_IDX || idx_ok_r)) begin
          count_r <= wr_ptr_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
    if (cmd.finish) begin
      out_status         <= ST_OK;
      out_found_index    <= '0;
      out_found_position <= '0;
      out_found_type     <= '0;
      out_found_left     <= '0;
      out_found_top      <= '0;
      out_found_right    <= '0;
      out_found_bottom   <= '0;
      case (op_r)
        OP_ADD: begin
          if (add_ok) begin
            out_found_index    <= 6'(count_r);
            out_found_position <= new_r.pos;
            out_found_type     <= new_r.typ;
            out_found_left     <= new_r.left;
            out_found_top      <= new_r.top;
            out_found_right    <= new_r.right;
            out_found_bottom   <= new_r.bottom;
          end else begin
            out_status <= ST_FULL;
          end
        end
        OP_REPLACE, OP_REM_KEYS, OP_REM_TYPE: begin
          out_status <= any_r ? ST_OK : ST_NOT_FOUND;
        end
        OP_REM_IDX: begin
          out_status <= idx_ok_r ? ST_OK : ST_NOT_FOUND;
        end
        OP_HIT, OP_LOOKUP: begin
          if (pend_r && hit) begin
            out_found_index    <= 6'(pend_addr_r);
            out_found_position <= rd_q_r.pos;
            out_found_type     <= rd_q_r.typ;
            out_found_left     <= rd_q_r.left;
            out_found_top      <= rd_q_r.top;
            out_found_right    <= rd_q_r.right;
            out_found_bottom   <= rd_q_r.bottom;
          end else begin
            out_status <= ST_NOT_FOUND;
          end
        end
        default: begin
          out_status <= ST_OK;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_rect_hit_test_table.sv =====
// Self-checking testbench for rect_hit_test_table.
// Drives opcode items through start/busy and writes entry_limit between phases.
// Checks every result strobe against a local table model; depends on rhtt_pkg.
module tb_rect_hit_test_table;
  import rhtt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  typedef struct {
    op_t                op;
    logic [15:0]        pos;
    logic [7:0]         typ;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        len;
    logic [14:0]        wid;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [5:0]         idx;
  } cmd_item_t;

  typedef struct {
    logic [1:0]         status;
    logic [5:0]         index;
    logic [15:0]        pos;
    logic [7:0]         typ;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [16:0] right;
    logic signed [16:0] bottom;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_opcode = '0;
  logic [15:0] in_key_position = '0;
  logic [7:0] in_key_type = '0;
  logic signed [15:0] in_rect_left = '0;
  logic signed [15:0] in_rect_top = '0;
  logic [14:0] in_rect_length = '0;
  logic [14:0] in_rect_width = '0;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic [5:0] in_entry_index = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [5:0] out_found_index;
  logic [15:0] out_found_position;
  logic [7:0] out_found_type;
  logic signed [15:0] out_found_left;
  logic signed [15:0] out_found_top;
  logic signed [16:0] out_found_right;
  logic signed [16:0] out_found_bottom;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_entry_limit = '0;

  rect_hit_test_table uut (.*);

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Table model state
  logic [15:0]        tab_pos [DEPTH];
  logic [7:0]         tab_typ [DEPTH];
  logic signed [15:0] tab_left [DEPTH];
  logic signed [15:0] tab_top [DEPTH];
  logic signed [16:0] tab_right [DEPTH];
  logic signed [16:0] tab_bottom [DEPTH];
  int unsigned tab_count = 0;
  logic [6:0]  tab_limit = LIMIT_RESET;

  cmd_item_t pending_items[$];
  table_result_t expected_results[$];
  cmd_item_t cur;
  logic took = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cyc = 0;

  function automatic table_result_t describe_entry(int unsigned i);
    table_result_t r;
    r.status = ST_OK;
    r.index  = i[5:0];
    r.pos    = tab_pos[i];
    r.typ    = tab_typ[i];
    r.left   = tab_left[i];
    r.top    = tab_top[i];
    r.right  = tab_right[i];
    r.bottom = tab_bottom[i];
    return r;
  endfunction

  function automatic void store_rect(int unsigned i, cmd_item_t c);
    tab_left[i]   = c.left;
    tab_top[i]    = c.top;
    tab_right[i]  = $signed({c.left[15], c.left}) + $signed({2'b00, c.len});
    tab_bottom[i] = $signed({c.top[15], c.top}) + $signed({2'b00, c.wid});
  endfunction

  function automatic void move_entry(int unsigned dst, int unsigned src);
    tab_pos[dst] = tab_pos[src];
    tab_typ[dst] = tab_typ[src];
    tab_left[dst] = tab_left[src];
    tab_top[dst] = tab_top[src];
    tab_right[dst] = tab_right[src];
    tab_bottom[dst] = tab_bottom[src];
  endfunction

  // Apply one item to the table model and return the expected result
  function automatic table_result_t apply_table_op(cmd_item_t c);
    table_result_t r;
    int unsigned eff;
    int unsigned j;
    r = '{default: '0};
    eff = (tab_limit < DEPTH) ? tab_limit : DEPTH;
    case (c.op)
      OP_ADD: begin
        if (tab_count >= eff) begin
          r.status = ST_FULL;
        end else begin
          tab_pos[tab_count] = c.pos;
          tab_typ[tab_count] = c.typ;
          store_rect(tab_count, c);
          r = describe_entry(tab_count);
          tab_count++;
        end
      end
      OP_REPLACE: begin
        r.status = ST_NOT_FOUND;
        for (int unsigned i = 0; i < tab_count; i++)
          if (tab_pos[i] == c.pos && tab_typ[i] == c.typ) begin
            store_rect(i, c);
            r.status = ST_OK;
          end
      end
      OP_REM_IDX: begin
        if (c.idx < tab_count) begin
          for (int unsigned i = c.idx; i + 1 < tab_count; i++) move_entry(i, i + 1);
          tab_count--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_REM_KEYS, OP_REM_TYPE: begin
        j = 0;
        for (int unsigned i = 0; i < tab_count; i++) begin
          if (tab_typ[i] == c.typ && (c.op == OP_REM_TYPE || tab_pos[i] == c.pos)) continue;
          move_entry(j, i);
          j++;
        end
        r.status = (j == tab_count) ? ST_NOT_FOUND : ST_OK;
        tab_count = j;
      end
      OP_HIT, OP_LOOKUP: begin
        r.status = ST_NOT_FOUND;
        for (int i = int'(tab_count) - 1; i >= 0; i--) begin
          if (c.op == OP_LOOKUP ? (tab_pos[i] == c.pos && tab_typ[i] == c.typ)
              : (int'(c.px) >= int'(tab_left[i]) && int'(c.px) < int'(tab_right[i]) &&
                 int'(c.py) >= int'(tab_top[i]) && int'(c.py) < int'(tab_bottom[i]))) begin
            r = describe_entry(i);
            break;
          end
        end
      end
      default: tab_count = 0;
    endcase
    return r;
  endfunction

  // Monitor: check result strobes, predict on accepted items
  always @(posedge clk) begin
    table_result_t e;
    if (out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); mismatches++;
        end
        if (out_found_index !== e.index) begin
          $error("found_index exp %0d got %0d", e.index, out_found_index); mismatches++;
        end
        if (out_found_position !== e.pos) begin
          $error("found_position exp %0d got %0d", e.pos, out_found_position); mismatches++;
        end
        if (out_found_type !== e.typ) begin
          $error("found_type exp %0d got %0d", e.typ, out_found_type); mismatches++;
        end
        if (out_found_left !== e.left) begin
          $error("found_left exp %0d got %0d", e.left, out_found_left); mismatches++;
        end
        if (out_found_top !== e.top) begin
          $error("found_top exp %0d got %0d", e.top, out_found_top); mismatches++;
        end
        if (out_found_right !== e.right) begin
          $error("found_right exp %0d got %0d", e.right, out_found_right); mismatches++;
        end
        if (out_found_bottom !== e.bottom) begin
          $error("found_bottom exp %0d got %0d", e.bottom, out_found_bottom); mismatches++;
        end
      end
    end
    if (rst_n && start && !busy) expected_results.push_back(apply_table_op(cur));
    took <= rst_n && start && !busy;
    cyc <= cyc + 1;
  end

  // Driver: hold an item until taken, then load the next or idle
  always @(negedge clk) begin
    if (rst_n && (took || !start)) begin
      if (pending_items.size() != 0 &&
          ((cyc % 4000) < 1500 || $urandom_range(0, 99) >= 10)) begin
        cur = pending_items.pop_front();
        in_opcode       <= cur.op;
        in_key_position <= cur.pos;
        in_key_type     <= cur.typ;
        in_rect_left    <= cur.left;
        in_rect_top     <= cur.top;
        in_rect_length  <= cur.len;
        in_rect_width   <= cur.wid;
        in_point_x      <= cur.px;
        in_point_y      <= cur.py;
        in_entry_index  <= cur.idx;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic cmd_item_t mk(op_t op, logic [15:0] pos, logic [7:0] typ,
                                   int l, int t, int len, int wid, int px, int py, int idx);
    cmd_item_t c;
    c.op = op; c.pos = pos; c.typ = typ;
    c.left = l[15:0]; c.top = t[15:0]; c.len = len[14:0]; c.wid = wid[14:0];
    c.px = px[15:0]; c.py = py[15:0]; c.idx = idx[5:0];
    return c;
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(0, 60)) - 30;
  endfunction

  // Random item: mostly small keys and coordinates so entries collide and get hit
  function automatic cmd_item_t random_item(int add_weight);
    cmd_item_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < add_weight) c.op = OP_ADD;
    else begin
      pick = $urandom_range(0, 99);
      if      (pick < 14) c.op = OP_REPLACE;
      else if (pick < 30) c.op = OP_REM_IDX;
      else if (pick < 42) c.op = OP_REM_KEYS;
      else if (pick < 50) c.op = OP_REM_TYPE;
      else if (pick < 75) c.op = OP_HIT;
      else if (pick < 95) c.op = OP_LOOKUP;
      else                c.op = OP_CLEAR;
    end
    c.pos = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    c.typ = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      c.left = 16'(small_coord()); c.top = 16'(small_coord());
      c.len = 15'($urandom_range(0, 30)); c.wid = 15'($urandom_range(0, 30));
      c.px = 16'(small_coord()); c.py = 16'(small_coord());
    end else begin
      c.left = 16'($urandom); c.top = 16'($urandom);
      c.len = 15'($urandom); c.wid = 15'($urandom);
      c.px = 16'($urandom); c.py = 16'($urandom);
    end
    c.idx = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    return c;
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_entry_limit <= value;
    do @(posedge clk);
    while (!cfg_ready);
    tab_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n, int add_weight);
    for (int k = 0; k < n; k++) pending_items.push_back(random_item(add_weight));
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table queries, edge extremes, half-open borders, each opcode
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_REM_IDX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_ADD, 16'hFFFF, 8'hFF, 32767, 32767, 32767, 32767, 0, 0, 0));
    pending_items.push_back(mk(OP_ADD, 0, 0, -32768, -32768, 32767, 32767, 0, 0, 0));
    pending_items.push_back(mk(OP_ADD, 5, 1, 10, 10, 0, 5, 0, 0, 0));
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, -32768, -32768, 0));
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, -2, -2, 0));
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, -1, -1, 0));
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 32767, 32767, 0));
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 10, 12, 0));
    pending_items.push_back(mk(OP_LOOKUP, 16'hFFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_REPLACE, 5, 1, -5, -5, 10, 10, 0, 0, 0));
    pending_items.push_back(mk(OP_REPLACE, 6, 1, 0, 0, 1, 1, 0, 0, 0));
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 4, 4, 0));
    pending_items.push_back(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 5, 4, 0));
    pending_items.push_back(mk(OP_REM_IDX, 0, 0, 0, 0, 0, 0, 0, 0, 63));
    pending_items.push_back(mk(OP_REM_IDX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_REM_KEYS, 9, 9, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_REM_KEYS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_REM_TYPE, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_REM_TYPE, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Phases over several limits; fill bursts reach the full condition
    write_limit(7'd2);
    run_random(120, 50);
    run_random(20, 100);
    write_limit(7'd0);
    run_random(40, 40);
    write_limit(7'd127);
    run_random(70, 100);
    run_random(280, 40);
    write_limit(7'd64);
    run_random(66, 100);
    run_random(350, 45);
    write_limit(7'd1);
    run_random(60, 40);
    write_limit(7'd100);
    run_random(200, 45);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
